// ===== hw/rtl/b64_enc_pkg.sv =====
// shared types, constants and alphabet lookup for the base64 encoder
package b64_enc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int unsigned GRP_DEPTH = 2;
    localparam int unsigned GRP_PTR_W = 1;
    localparam int unsigned GRP_CNT_W = 2;

    // one closed group of up to three bytes
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] byte_cnt;
        logic       eom;
    } t_group;

    function automatic logic [7:0] f_b64_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s} - 8'd26;
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s} - 8'd52;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/b64_enc_fifo.sv =====
// two-entry group queue between the byte collector and the character emitter
module b64_enc_fifo
    import b64_enc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_group i_wr_grp,
    input  logic   i_pop,
    output t_group o_rd_grp,
    output logic   o_full,
    output logic   o_empty
);

    t_group                 r_mem [GRP_DEPTH];
    logic [GRP_PTR_W-1:0]   r_wp;
    logic [GRP_PTR_W-1:0]   r_rp;
    logic [GRP_CNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_wr_grp;
        end
    end

    assign o_rd_grp = r_mem[r_rp];
    assign o_full   = (r_count == GRP_CNT_W'(GRP_DEPTH));
    assign o_empty  = (r_count == '0);

endmodule

// ===== hw/rtl/b64_enc_front.sv =====
// byte collector: holds pending bytes and closes groups on the third byte or message end
module b64_enc_front
    import b64_enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_eom,
    input  logic       i_q_full,
    output logic       o_ready,
    output logic       o_push,
    output t_group     o_grp
);

    logic [7:0] r_held [2];
    logic [1:0] r_cnt;
    logic       w_acc;
    logic       w_close;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && o_ready;
    assign w_close = (r_cnt[1] || i_eom);
    assign o_push  = w_acc && w_close;

    always_comb begin
        o_grp     = '0;
        o_grp.eom = i_eom;
        if (r_cnt[1]) begin
            o_grp.b0       = r_held[0];
            o_grp.b1       = r_held[1];
            o_grp.b2       = i_byte;
            o_grp.byte_cnt = 2'd3;
        end else if (r_cnt == 2'd0) begin
            o_grp.b0       = i_byte;
            o_grp.byte_cnt = 2'd1;
        end else begin
            o_grp.b0       = r_held[0];
            o_grp.b1       = i_byte;
            o_grp.byte_cnt = 2'd2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_held[0] <= '0;
            r_held[1] <= '0;
        end else if (w_acc) begin
            if (w_close) begin
                r_cnt <= '0;
            end else begin
                r_held[r_cnt[0]] <= i_byte;
                r_cnt            <= r_cnt + 2'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/b64_enc_back.sv =====
// character emitter: turns one group into four characters, one per cycle while the output port accepts them
module b64_enc_back
    import b64_enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_group     i_grp,
    input  logic       i_q_empty,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_char,
    output logic       o_last
);

    t_group     r_grp;
    logic       r_have;
    logic [1:0] r_idx;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_last;
    logic       w_out_free;
    logic       w_emit;
    logic [5:0] w_sext;
    logic [7:0] w_char;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_emit     = r_have && w_out_free;
    assign o_pop      = !i_q_empty && (!r_have || (w_emit && r_idx == 2'd3));

    always_comb begin
        case (r_idx)
            2'd0:    w_sext = r_grp.b0[7:2];
            2'd1:    w_sext = {r_grp.b0[1:0], r_grp.b1[7:4]};
            2'd2:    w_sext = {r_grp.b1[3:0], r_grp.b2[7:6]};
            default: w_sext = r_grp.b2[5:0];
        endcase
        // pad positions past the data bytes
        if ((r_idx == 2'd2 && r_grp.byte_cnt < 2'd2) ||
            (r_idx == 2'd3 && r_grp.byte_cnt < 2'd3)) begin
            w_char = PAD_CHAR;
        end else begin
            w_char = f_b64_char(w_sext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_have <= 1'b1;
                r_idx  <= '0;
            end else if (w_emit) begin
                r_idx <= r_idx + 2'd1;
                if (r_idx == 2'd3) begin
                    r_have <= 1'b0;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_grp <= i_grp;
        end
        if (w_emit) begin
            r_out_char <= w_char;
            r_out_last <= (r_idx == 2'd3) && r_grp.eom;
        end
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

// ===== hw/rtl/base64_encoder.sv =====
// base64 encoder top level: byte collector, group queue, character emitter
// the first character of a group passes through the group queue, the emitter group register and the output register
// throughput: one character per cycle while the output port accepts them, four characters per group
// input takes one item per cycle while the two-entry group queue has room
// synchronous active-low reset empties the queue and drops held bytes
module base64_encoder
    import b64_enc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // end_of_message
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] code_char
    output logic       m_axis_tlast    // last_char
);

    t_group w_wr_grp;
    t_group w_rd_grp;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;

    b64_enc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_eom    (s_axis_tlast),
        .i_q_full (w_full),
        .o_ready  (s_axis_tready),
        .o_push   (w_push),
        .o_grp    (w_wr_grp)
    );

    b64_enc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_wr_grp (w_wr_grp),
        .i_pop    (w_pop),
        .o_rd_grp (w_rd_grp),
        .o_full   (w_full),
        .o_empty  (w_empty)
    );

    b64_enc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_grp     (w_rd_grp),
        .i_q_empty (w_empty),
        .o_pop     (w_pop),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_char    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("group pushed into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("group popped from empty queue");
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_full && w_empty))
        else $error("queue full and empty at once");
    a_push_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> !w_empty)
        else $error("queue empty after push");
`endif

endmodule

// ===== tb/base64_encoder_tb.sv =====
// testbench for the base64 encoder: directed and random byte messages with idling, checked char by char
`timescale 1ns / 100ps

module base64_encoder_tb;
    import b64_enc_pkg::PAD_CHAR;

    localparam logic [511:0] B64_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int RANDOM_BYTES = 96;
    localparam int HOLD_CYCLES  = 160;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
    } t_raw_byte;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_b64_char;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast  = 1'b0;    // end_of_message
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] code_char
    logic       m_axis_tlast;            // last_char

    t_raw_byte pending_bytes[$];
    t_b64_char expected_chars[$];

    // encoder state mirrored on the testbench side
    logic [7:0] held_bytes [2] = '{8'h00, 8'h00};
    logic [1:0] held_cnt = 2'd0;

    int tx_wait, tx_calm, rx_wait, rx_calm;
    int n_chars   = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int n_errors  = 0;

    base64_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [7:0] b64_symbol(input logic [5:0] s);
        return B64_SYMBOLS[8 * (63 - s) +: 8];
    endfunction

    // wait before the next item; now and then a run of items with no wait at all
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // collect bytes into 24-bit groups and queue the four chars each group makes
    task automatic encode_byte(input logic [7:0] b, input logic eom);
        logic [23:0] grp;
        int          n_bytes;
        if (held_cnt >= 2'd2) begin
            grp     = {held_bytes[0], held_bytes[1], b};
            n_bytes = 3;
        end else if (eom) begin
            grp     = (held_cnt == 2'd0) ? {b, 16'h0000} : {held_bytes[0], b, 8'h00};
            n_bytes = int'(held_cnt) + 1;
        end else begin
            held_bytes[held_cnt[0]] = b;
            held_cnt = held_cnt + 2'd1;
            return;
        end
        held_cnt   = 2'd0;
        held_bytes = '{8'h00, 8'h00};
        for (int k = 0; k < 4; k++) begin
            expected_chars.push_back('{ch:   (k <= n_bytes) ? b64_symbol(grp[23 - 6 * k -: 6])
                                                            : PAD_CHAR,
                                       last: (k == 3) && eom});
        end
    endtask

    task automatic add_message(input logic [7:0] bytes[], input bit close);
        for (int i = 0; i < bytes.size(); i++) begin
            pending_bytes.push_back('{data: bytes[i], eom: close && (i == bytes.size() - 1)});
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        t_raw_byte nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_wait = $urandom_range(0, 9);
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                encode_byte(s_axis_tdata, s_axis_tlast);
                tx_wait = draw_wait(tx_calm);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_bytes.size() > 0) begin
                    nxt = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.eom;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_b64_char want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_chars <= n_chars + 1;
                if (expected_chars.size() == 0) begin
                    n_errors++;
                    $display("%0t: unexpected item, expected none, actual char %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.ch) begin
                        n_errors++;
                        $display("%0t: code_char expected %h actual %h",
                                 $time, want.ch, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last) begin
                        n_errors++;
                        $display("%0t: last_char expected %b actual %b",
                                 $time, want.last, m_axis_tlast);
                    end
                end
                rx_wait = draw_wait(rx_calm);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    // one long receiver stall while the sender keeps offering bytes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (!hold_done && n_chars >= 40) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        logic [7:0] msg[];
        int         n_random;
        int         len;

        // single byte, both pad chars
        add_message('{8'h00}, 1'b1);
        add_message('{8'hFF}, 1'b1);
        // two bytes, one pad char
        add_message('{8'hFB, 8'hEF}, 1'b1);
        // full group on the last byte, no padding
        add_message('{8'h00, 8'h10, 8'h83}, 1'b1);
        add_message('{8'hFF, 8'hFF, 8'hFF}, 1'b1);
        // a full group followed by partial tails
        add_message('{8'h14, 8'hFB, 8'h9C, 8'h03, 8'hD9}, 1'b1);
        add_message('{8'h4D, 8'h61, 8'h6E, 8'h55}, 1'b1);

        n_random = 0;
        while (n_random < RANDOM_BYTES) begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            msg = new[len];
            foreach (msg[i]) begin
                case ($urandom_range(0, 9))
                    0:       msg[i] = 8'h00;
                    1:       msg[i] = 8'hFF;
                    default: msg[i] = 8'($urandom_range(0, 255));
                endcase
            end
            add_message(msg, 1'b1);
            n_random += len;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_axis_tvalid || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
